// ----- src/pnt_pkg.sv -----
// ----------------------------------------------------------------------------
// pnt_pkg: shared definitions for the perfect number test
// Holds the default data width and the status group of the shared divider.
// ----------------------------------------------------------------------------
package pnt_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- src/pnt_in_if.sv -----
// ----------------------------------------------------------------------------
// pnt_in_if: input channel of the perfect number test
// Carries one signed value per transfer with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface pnt_in_if #(
    parameter int VALUE_WIDTH = pnt_pkg::VALUE_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// ----- src/pnt_out_if.sv -----
// ----------------------------------------------------------------------------
// pnt_out_if: result channel of the perfect number test
// Carries one result flag per transfer with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface pnt_out_if;
    logic valid;
    logic ready;
    logic is_perfect;

    modport source (output valid, output is_perfect, input ready);
    modport sink (input valid, input is_perfect, output ready);
endinterface

// ----- src/perfect_number_test.sv -----
// ----------------------------------------------------------------------------
// perfect_number_test: tells whether a signed integer is a perfect number
// Sums proper divisors by trial division with one shared iterative divider.
// ----------------------------------------------------------------------------
//  Port     Direction  Payload                        Handshake
//  item     in         value (VALUE_WIDTH, signed)    valid / ready
//  result   out        is_perfect (1 bit)             valid / ready
//
//  A negative value, zero or one goes from S_IDLE straight to S_FINISH.
//  Otherwise each trial divisor d with d*d <= value passes S_CHECK, the divider
//  and S_STEP, and when d divides the value also S_ADD_D, S_ADD_Q (when the
//  cofactor differs from d) and S_TEST.
//  The search ends early once the divisor sum passes the value.
//  Reset clears the sequencer and the result valid flag; no clearing pass.
//  A stalled result holds in its register; the next item is taken meanwhile.
module perfect_number_test #(
    parameter int VALUE_WIDTH = pnt_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic      clk,
    input logic      rst_n,
    pnt_in_if.sink   item,
    pnt_out_if.source result
);
    import pnt_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int N  = W - 1;
    localparam int DW = (W + 1) / 2 + 1;
    localparam int AW = W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_ADD_D  = 3'd3;
    localparam logic [2:0] S_ADD_Q  = 3'd4;
    localparam logic [2:0] S_TEST   = 3'd5;
    localparam logic [2:0] S_STEP   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [N-1:0]  n_reg, n_next;
    logic [DW-1:0] d_reg, d_next;
    logic [W-1:0]  sq_reg, sq_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_bit_reg, out_bit_next;

    logic          div_start;
    div_status_t   div_status;
    logic [N-1:0]  quotient;
    logic [DW-1:0] remainder;
    logic [N-1:0]  n_in;
    logic [AW-1:0] n_wide;

    assign n_in   = item.value[N-1:0];
    assign n_wide = {2'b00, n_reg};

    pnt_div #(
        .N(N),
        .M(DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .status    (div_status),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        div_start      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    n_next   = n_in;
                    d_next   = DW'(2);
                    sq_next  = W'(4);
                    acc_next = AW'(1);
                    res_next = 1'b0;
                    if (item.value[W-1] || (n_in[N-1:1] == '0))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    res_next   = (acc_reg == n_wide);
                    state_next = S_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = (remainder == '0) ? S_ADD_D : S_STEP;
                end
            end
            S_ADD_D:
            begin
                acc_next = acc_reg + {{(AW-DW){1'b0}}, d_reg};
                if (quotient != {{(N-DW){1'b0}}, d_reg})
                begin
                    state_next = S_ADD_Q;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_ADD_Q:
            begin
                acc_next   = acc_reg + {2'b00, quotient};
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (acc_reg > n_wide)
                begin
                    res_next   = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                d_next     = d_reg + DW'(1);
                sq_next    = sq_reg + {{(W-DW-1){1'b0}}, d_reg, 1'b1};
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        out_bit_reg <= out_bit_next;
    end

    assign item.ready        = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.is_perfect = out_bit_reg;

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_CHECK) && !div_status.busy)
        else $error("divider started while busy");
    a_square_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |->
            ({{(2*W-DW){1'b0}}, d_reg} * {{(2*W-DW){1'b0}}, d_reg})
                == {{W{1'b0}}, sq_reg})
        else $error("square of trial divisor out of step");
    a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && div_status.done) |->
            ({{(W+1){1'b0}}, quotient} * {{(2*W-DW){1'b0}}, d_reg}
                + {{(2*W-DW){1'b0}}, remainder}) == {{(W+1){1'b0}}, n_reg})
        else $error("division result does not rebuild the value");
endmodule

// ----- src/pnt_div.sv -----
// ----------------------------------------------------------------------------
// pnt_div: iterative restoring divider
// Produces quotient and remainder of an unsigned division, one bit per cycle.
// ----------------------------------------------------------------------------
module pnt_div #(
    parameter int N = 31,
    parameter int M = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [N-1:0]         dividend,
    input  logic [M-1:0]         divisor,
    output pnt_pkg::div_status_t status,
    output logic [N-1:0]         quotient,
    output logic [M-1:0]         remainder
);
    import pnt_pkg::*;

    localparam int CW = $clog2(N + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic [N-1:0]  quot_reg, quot_next;
    logic [M-1:0]  rem_reg, rem_next;
    logic [M-1:0]  dvs_reg, dvs_next;
    logic [M:0]    shifted;
    logic [M+1:0]  trial;

    assign shifted = {rem_reg, quot_reg[N-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(N);
            quot_next  = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[M+1])
            begin
                rem_next  = trial[M-1:0];
                quot_next = {quot_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[M-1:0];
                quot_next = {quot_reg[N-2:0], 1'b0};
            end
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;
    assign remainder   = rem_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != '0)
        else $error("divider busy with no bits left");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");
endmodule

// ----- tb/sv/perfect_number_test_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perfect_number_test_test: self-checking bench for the perfect number test
// Sends signed values over the item channel and compares every result flag
// against a divisor-sum predictor. Directed values cover signs, the range
// limits, squares and known perfect numbers. Random values then run under
// several idle and stall mixes, and a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module perfect_number_test_test;
    import pnt_pkg::*;

    localparam int W = VALUE_WIDTH_DEFAULT;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SMALL_PERFECT[4] = '{6, 28, 496, 8128};
    localparam int MAX_MULTIPLE = int'(((64'sd1 <<< (W - 1)) - 64'sd1) / 64'sd12);

    typedef logic signed [W-1:0] value_t;

    typedef struct {
        value_t value;
        bit     is_perfect;
    } verdict_t;

    logic     clk = 1'b0;
    logic     rst_n;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    bit       hold_armed = 1'b0;
    bit       hold_taken = 1'b0;
    int       hold_left = 0;
    int       mismatch_count = 0;
    verdict_t pending_verdicts[$];

    pnt_in_if #(.VALUE_WIDTH(W)) item_if ();
    pnt_out_if                   result_if ();

    perfect_number_test #(
        .VALUE_WIDTH(W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .result(result_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit perfect_flag(value_t v);
        longint unsigned n;
        longint unsigned divisor_sum;
        longint unsigned d;
        longint unsigned q;
        if (v < 2)
        begin
            return 1'b0;
        end
        n = longint'(v);
        divisor_sum = 1;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
            begin
                q = n / d;
                divisor_sum += d;
                if (q != d)
                begin
                    divisor_sum += q;
                end
                if (divisor_sum > n)
                begin
                    return 1'b0;
                end
            end
        end
        return divisor_sum == n;
    endfunction

    function automatic value_t random_value();
        value_t v;
        case ($urandom_range(9))
            0, 1, 2:
            begin
                v = value_t'($urandom());
                v[W-1] = 1'b1;
            end
            3, 4:    v = value_t'(12 * $urandom_range(1, MAX_MULTIPLE));
            5:       v = value_t'(SMALL_PERFECT[$urandom_range(3)]);
            6:       v = value_t'($urandom_range(3));
            default: v = value_t'($urandom_range(4, 65535));
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] %s", $time, what);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_value(value_t v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.value <= v;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        pending_verdicts.push_back('{v, perfect_flag(v)});
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_armed && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES - 1;
            result_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            result_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        verdict_t want;
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("result transfer with no item outstanding");
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_if.is_perfect !== want.is_perfect)
                begin
                    report_mismatch($sformatf("value %0d: is_perfect %b, expected %b",
                        want.value, result_if.is_perfect, want.is_perfect));
                end
            end
        end
    end

    task automatic test_special_values();
        value_t specials[13] = '{
            32'sh8000_0000, -32'sd1, -32'sd6, 32'sd0, 32'sd1, 32'sd2, 32'sd3,
            32'sd4, 32'sd12, 32'sd25, 32'sd24, 32'sd945, 32'sd8129
        };
        foreach (specials[i])
        begin
            send_value(specials[i]);
        end
    endtask

    task automatic test_perfect_numbers();
        value_t perfects[6] = '{
            32'sd6, 32'sd28, 32'sd496, 32'sd8128, 32'sd8127, 32'sd33550336
        };
        foreach (perfects[i])
        begin
            send_value(perfects[i]);
        end
    endtask

    task automatic test_largest_values();
        send_value(32'sh7FFF_FFF8);
        send_value(32'sh7FFF_FFFF);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
        begin
            send_value(random_value());
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_armed = 1'b1;
        repeat (8)
        begin
            send_value(value_t'($urandom_range(2, 100)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.value = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_special_values();
        test_perfect_numbers();
        test_largest_values();
        test_random_phase(0, 0, 20);
        test_random_phase(85, 0, 20);
        test_random_phase(0, 85, 20);
        test_random_phase(17, 17, 20);
        test_backpressure();

        item_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("perfect_number_test: match");
        end
        else
        begin
            $display("perfect_number_test: mismatch");
        end
        $finish;
    end

    initial
    begin
        #250_000_000;
        $display("perfect_number_test: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
src/pnt_pkg.sv
src/pnt_in_if.sv
src/pnt_out_if.sv
src/pnt_div.sv
src/perfect_number_test.sv
tb/sv/perfect_number_test_test.sv
